>>> sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros for the signed integer to decimal text converter.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, off during reset
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int MagW         = 32;
	localparam int DigW         = 4;
	localparam int NumDig       = 10;
	localparam int BcdW         = NumDig * DigW;
	localparam int DabSteps     = 4;
	localparam int NumDabStages = MagW / DabSteps;
	localparam int IdxW         = $clog2(NumDig);

	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] CharZero  = 8'd48;

	// Word carried down the shift-add-3 pipeline
	typedef struct packed {
		logic            neg;
		logic [BcdW-1:0] bcd;
		logic [MagW-1:0] bin;
	} dab_word_t;

endpackage

>>> sv/sitda_dab_stage.sv
// One pipeline stage of the binary to BCD conversion (several shift-add-3 steps).
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_dab_stage
	import sitda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dab_word_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output dab_word_t out_data
);

	logic      vld_s1;
	dab_word_t dat_s1;
	dab_word_t work;

	// Take a new word when empty or when the next stage drains this one
	assign in_ready = !vld_s1 || out_ready;

	// Correct each digit of five or more, then shift one binary bit in
	always_comb begin
		work = in_data;
		for (int s = 0; s < DabSteps; s++) begin
			for (int d = 0; d < NumDig; d++) begin
				if (work.bcd[d*DigW +: DigW] >= 4'd5) begin
					work.bcd[d*DigW +: DigW] = work.bcd[d*DigW +: DigW] + 4'd3;
				end
			end
			{work.bcd, work.bin} = {work.bcd[BcdW-2:0], work.bin, 1'b0};
		end
	end

	// Hold valid with the data; advance on ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= work;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

endmodule

>>> sv/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
// Depends on sitda_pkg, sitda_dab_stage and signed_int_to_decimal_ascii_macros.svh.
//
//   channel   handshake        payload
//   -------   --------------   ---------------------
//   input     start / busy     value
//   result    strobe           ascii_char, last_char
//
// A word is taken when start is high and busy is low; a new word may enter every cycle.
// The first character passes the input register, 8 conversion stages of 4 shift-add-3
// steps each, the character serializer and the output register.
// The serializer sends one character per cycle, so a value of n characters (1 to 11)
// holds it until done; that sets the sustained rate. busy rises when the pipe backs up.
// Reset clears all valid bits; no clearing pass is needed. The receiver cannot stall.
`timescale 1ns / 1ps

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [MagW-1:0] value,
	output logic                   strobe,
	output logic [7:0]             ascii_char,
	output logic                   last_char
);

	logic            valid_s1;
	dab_word_t       word_s1;
	logic            accept;
	logic [MagW-1:0] mag;

	dab_word_t dab_data [NumDabStages+1];
	logic      dab_vld  [NumDabStages+1];
	logic      dab_rdy  [NumDabStages+1];

	logic            active_q;
	logic            sign_pend_q;
	logic [BcdW-1:0] bcd_q;
	logic [IdxW-1:0] idx_q;
	logic            emit_last;
	logic            tail_ready;
	logic [DigW-1:0] cur_dig;

	logic            strobe_q;
	logic [7:0]      ascii_char_q;
	logic            last_char_q;

	// Index of the most significant nonzero digit; zero for a zero value
	function automatic logic [IdxW-1:0] lead_digit(input logic [BcdW-1:0] bcd);
		logic [IdxW-1:0] top;
		top = '0;
		for (int j = 0; j < NumDig; j++) begin
			if (bcd[j*DigW +: DigW] != '0) begin
				top = IdxW'(j);
			end
		end
		return top;
	endfunction

	// Input register: sign and unsigned magnitude
	assign busy   = valid_s1 && !dab_rdy[0];
	assign accept = start && !busy;
	assign mag    = value[MagW-1] ? (~value + 1'b1) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.neg <= value[MagW-1];
			word_s1.bcd <= '0;
			word_s1.bin <= mag;
		end
	end

	assign dab_data[0] = word_s1;
	assign dab_vld[0]  = valid_s1;

	// Binary to BCD pipeline
	for (genvar g = 0; g < NumDabStages; g++) begin : g_dab
		sitda_dab_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dab_vld[g]),
			.in_ready (dab_rdy[g]),
			.in_data  (dab_data[g]),
			.out_valid(dab_vld[g+1]),
			.out_ready(dab_rdy[g+1]),
			.out_data (dab_data[g+1])
		);
	end

	// Character serializer: sign first, then digits from the leading one down
	assign cur_dig    = bcd_q[{idx_q, 2'b00} +: DigW];
	assign emit_last  = active_q && !sign_pend_q && (idx_q == '0);
	assign tail_ready = !active_q || emit_last;
	assign dab_rdy[NumDabStages] = tail_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			sign_pend_q <= 1'b0;
		end else if (tail_ready) begin
			active_q    <= dab_vld[NumDabStages];
			sign_pend_q <= dab_vld[NumDabStages] && dab_data[NumDabStages].neg;
		end else if (sign_pend_q) begin
			sign_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_ready) begin
			bcd_q <= dab_data[NumDabStages].bcd;
			idx_q <= lead_digit(dab_data[NumDabStages].bcd);
		end else if (active_q && !sign_pend_q) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		ascii_char_q <= sign_pend_q ? CharMinus : (CharZero + {4'b0000, cur_dig});
		last_char_q  <= !sign_pend_q && (idx_q == '0);
	end

	assign strobe     = strobe_q;
	assign ascii_char = ascii_char_q;
	assign last_char  = last_char_q;

	// Checks
	`SITDA_ASSERT_NOW(a_sign_not_last, strobe_q && (ascii_char_q == CharMinus), !last_char_q, "sign character flagged as last")
	`SITDA_ASSERT_NEXT(a_digit_after_sign, strobe_q && (ascii_char_q == CharMinus), strobe_q && (ascii_char_q != CharMinus), "sign not followed by a digit")
	`SITDA_ASSERT_NOW(a_char_code, strobe_q, (ascii_char_q == CharMinus) || ((ascii_char_q >= CharZero) && (ascii_char_q <= CharZero + 8'd9)), "character outside sign and digits")
	`SITDA_ASSERT_NEXT(a_text_continues, active_q && !emit_last, active_q, "serializer dropped a text before its last character")

endmodule
